>>> design/efcs_pkg.sv
// package for the earliest-free core scheduler
// holds field widths, parameter defaults and the sequencer state type; no dependencies
`default_nettype none

package efcs_pkg;

    // default sizing of the core table
    localparam int MAX_CORES_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    // fixed widths of the port fields
    localparam int CFG_W   = 5;
    localparam int REQ_W   = 32;
    localparam int LEN_W   = 16;
    localparam int CORE_W  = 4;
    localparam int START_W = 32;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

endpackage

`default_nettype wire

>>> design/earliest_free_core_scheduler.sv
// Earliest-free core scheduler: assigns each job to a core and reports the start time.
// An item is taken when start is high and busy is low. The block then walks the
// busy-until table of the active cores one core per cycle through a single read
// port and one compare unit, then writes the chosen core back in a separate write
// state: busy stays high until that write is done, and the result appears with
// o_done for exactly one cycle right after busy falls. The receiver cannot stall
// the block; each result transfer happens in the cycle that o_done is high. The
// busy-until table clears at reset through per-core valid bits, with no clearing
// pass. The configuration channel is always ready; write active_cores only while
// the block is idle.
// depends on efcs_pkg
`default_nettype none

module earliest_free_core_scheduler #(
    parameter int MAX_CORES = efcs_pkg::MAX_CORES_DEF,
    parameter int TIME_BITS = efcs_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [efcs_pkg::CFG_W-1:0]    i_cfg_data,
    // command side
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [efcs_pkg::REQ_W-1:0]    i_request_time,
    input  wire logic [efcs_pkg::LEN_W-1:0]    i_job_length,
    // result side
    output logic                               o_done,
    output logic [efcs_pkg::CORE_W-1:0]        o_chosen_core,
    output logic [efcs_pkg::START_W-1:0]       o_start_time
);

    localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNT_W = $clog2(MAX_CORES + 1);
    localparam int SUM_W = ((TIME_BITS > efcs_pkg::LEN_W) ? TIME_BITS : efcs_pkg::LEN_W) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    efcs_pkg::t_state r_state;

    logic [efcs_pkg::CFG_W-1:0]  r_active;
    logic [MAX_CORES-1:0]        r_valid;
    logic [TIME_BITS-1:0]        r_mem [MAX_CORES];

    logic [CNT_W-1:0]            r_idx;
    logic                        r_cmp_vld;
    logic [IDX_W-1:0]            r_cmp_idx;
    logic [TIME_BITS-1:0]        r_rd_data;
    logic                        r_rd_vbit;

    logic [TIME_BITS-1:0]        r_req;
    logic [efcs_pkg::LEN_W-1:0]  r_len;
    logic                        r_found;
    logic [IDX_W-1:0]            r_pick;
    logic [TIME_BITS-1:0]        r_min;
    logic [IDX_W-1:0]            r_min_idx;

    logic                        r_done;
    logic [efcs_pkg::CORE_W-1:0] r_core_out;
    logic [efcs_pkg::START_W-1:0] r_start_out;

    logic [CNT_W-1:0]            w_n;
    logic [IDX_W-1:0]            w_last;
    logic                        w_accept;
    logic                        w_issue;
    logic [IDX_W-1:0]            w_rd_addr;
    logic [TIME_BITS-1:0]        w_busy;
    logic                        w_free;
    logic                        w_less;
    logic                        w_scan_end;
    logic [TIME_BITS-1:0]        w_start;
    logic [IDX_W-1:0]            w_pick;
    logic [SUM_W-1:0]            w_sum;
    logic [TIME_BITS-1:0]        w_end;

    // clamp the active core count to 1..MAX_CORES
    always_comb begin
        priority if (r_active == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_active) > MAX_CORES) begin
            w_n = CNT_W'(MAX_CORES);
        end else begin
            w_n = CNT_W'(r_active);
        end
    end
    assign w_last = IDX_W'(w_n - CNT_W'(1));

    assign w_accept    = start && (r_state == efcs_pkg::S_IDLE);
    assign w_issue     = (r_state == efcs_pkg::S_SCAN) && (r_idx < w_n);
    assign w_rd_addr   = r_idx[IDX_W-1:0];

    // shared compare unit on the entry just read
    assign w_busy      = r_rd_vbit ? r_rd_data : '0;
    assign w_free      = (w_busy <= r_req);
    assign w_less      = (r_cmp_idx == '0) || (w_busy < r_min);
    assign w_scan_end  = r_cmp_vld && (r_cmp_idx == w_last);

    // pick and saturating end time for the write-back
    assign w_start = r_found ? r_req : r_min;
    assign w_pick  = r_found ? r_pick : r_min_idx;
    assign w_sum   = SUM_W'(w_start) + SUM_W'(r_len);
    assign w_end   = (w_sum > SUM_W'(TMAX)) ? TMAX : w_sum[TIME_BITS-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= efcs_pkg::S_IDLE;
            r_active  <= efcs_pkg::CFG_W'(16);
            r_valid   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            unique case (r_state)
                efcs_pkg::S_IDLE: begin
                    if (start) begin
                        r_state   <= efcs_pkg::S_SCAN;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_found   <= 1'b0;
                    end
                end
                efcs_pkg::S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    r_cmp_vld <= w_issue;
                    if (r_cmp_vld && !r_found && w_free) begin
                        r_found <= 1'b1;
                    end
                    if (w_scan_end) begin
                        r_state   <= efcs_pkg::S_WRITE;
                        r_cmp_vld <= 1'b0;
                    end
                end
                efcs_pkg::S_WRITE: begin
                    r_valid[w_pick] <= 1'b1;
                    r_done          <= 1'b1;
                    r_state         <= efcs_pkg::S_IDLE;
                end
                default: begin
                    r_state <= efcs_pkg::S_IDLE;
                end
            endcase
        end
    end

    // busy-until table: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vbit <= r_valid[w_rd_addr];
            r_cmp_idx <= w_rd_addr;
        end
        if (r_state == efcs_pkg::S_WRITE) begin
            r_mem[w_pick] <= w_end;
        end
    end

    // job payload, running search results and output registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= TIME_BITS'(i_request_time);
            r_len <= i_job_length;
        end
        if (r_state == efcs_pkg::S_SCAN && r_cmp_vld) begin
            if (!r_found && w_free) begin
                r_pick <= r_cmp_idx;
            end
            if (w_less) begin
                r_min     <= w_busy;
                r_min_idx <= r_cmp_idx;
            end
        end
        if (r_state == efcs_pkg::S_WRITE) begin
            r_core_out  <= efcs_pkg::CORE_W'(w_pick);
            r_start_out <= efcs_pkg::START_W'(w_start);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign busy          = (r_state != efcs_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_chosen_core = r_core_out;
    assign o_start_time  = r_start_out;

endmodule

`default_nettype wire
